/* rtl/core/dad_pkg.sv */
`default_nettype none
package dad_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned AddW   = 16;
  // Day accumulator: start day plus the day count.
  localparam int unsigned SumW   = AddW + 1;
  // Century quotient and remainder of the year.
  localparam int unsigned CentW  = 8;
  localparam int unsigned RemW   = 7;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // floor(y / 100) == (y * RecipHundred) >> RecipShift for every 14-bit y.
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int unsigned RecipShift   = 19;
  localparam logic [6:0]  Hundred      = 7'd100;
  localparam logic [RemW-1:0] LastRem  = 7'd99;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [YearW-1:0]  YearMax  = 14'h3FFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_RUN,
    ST_EMIT
  } dad_state_t;

  typedef struct packed {
    logic load;
    logic quot;
    logic rem;
    logic step;
    logic emit;
  } dad_cmd_t;

  typedef struct packed {
    logic bad;
    logic fits;
    logic out_free;
  } dad_sts_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/dad_ctrl.sv */
`default_nettype none
module dad_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire dad_pkg::dad_sts_t sts,
  output dad_pkg::dad_cmd_t      cmd
);
  import dad_pkg::*;

  dad_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_QUOT;
      end
      ST_QUOT: begin
        state_nxt = sts.bad ? ST_EMIT : ST_REM;
      end
      ST_REM: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.fits) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_QUOT: begin
        cmd.quot = 1'b1;
      end
      ST_REM: begin
        cmd.rem = 1'b1;
      end
      ST_RUN: begin
        cmd.step = !sts.fits;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/dad_datapath.sv */
`default_nettype none
module dad_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [dad_pkg::InDataW-1:0]      in_tdata,
  input  wire dad_pkg::dad_cmd_t                cmd,
  output dad_pkg::dad_sts_t                     sts,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [dad_pkg::OutDataW-1:0]          out_tdata,
  output logic                                  out_tuser
);
  import dad_pkg::*;

  logic [YearW-1:0]  in_year;
  logic [MonthW-1:0] in_month;
  logic [DayW-1:0]   in_day;
  logic [AddW-1:0]   in_add;
  logic              in_bad;

  logic [YearW-1:0]  year_r;
  logic [MonthW-1:0] month_r;
  logic [SumW-1:0]   day_r;
  logic              bad_r;
  logic [CentW-1:0]  cent_r;
  logic [RemW-1:0]   rem_r;

  logic [YearW+12:0] quot_prod;
  logic [CentW+6:0]  cent_prod;
  logic [YearW-1:0]  rem_full;
  logic              leap;
  logic [DayW-1:0]   cur_len;

  logic              out_valid_r;
  logic [YearW-1:0]  out_year_r;
  logic [MonthW-1:0] out_month_r;
  logic [DayW-1:0]   out_day_r;
  logic              out_bad_r;

  assign in_year  = in_tdata[13:0];
  assign in_month = in_tdata[17:14];
  assign in_day   = in_tdata[22:18];
  assign in_add   = in_tdata[38:23];
  assign in_bad   = (in_month == '0) || (in_month > MonthDec);

  assign quot_prod = year_r * RecipHundred;
  assign cent_prod = cent_r * Hundred;
  assign rem_full  = year_r - cent_prod[YearW-1:0];

  // Century years are leap only when the century count is a multiple of four.
  assign leap    = (rem_r == '0) ? (cent_r[1:0] == 2'b00) : (year_r[1:0] == 2'b00);
  assign cur_len = month_len(month_r, leap);

  assign sts.bad      = bad_r;
  assign sts.fits     = day_r <= {{(SumW-DayW){1'b0}}, cur_len};
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r  <= in_year;
      month_r <= in_month;
      bad_r   <= in_bad;
      day_r   <= in_bad ? {{(SumW-DayW){1'b0}}, in_day}
                        : {{(SumW-DayW){1'b0}}, in_day} + {1'b0, in_add};
    end else if (cmd.step) begin
      day_r <= day_r - {{(SumW-DayW){1'b0}}, cur_len};
      if (month_r == MonthDec) begin
        month_r <= MonthJan;
        year_r  <= year_r + 1'b1;
        if (year_r == YearMax) begin
          cent_r <= '0;
          rem_r  <= '0;
        end else if (rem_r == LastRem) begin
          rem_r  <= '0;
          cent_r <= cent_r + 1'b1;
        end else begin
          rem_r <= rem_r + 1'b1;
        end
      end else begin
        month_r <= month_r + 1'b1;
      end
    end
    if (cmd.quot) begin
      cent_r <= quot_prod[RecipShift +: CentW];
    end
    if (cmd.rem) begin
      rem_r <= rem_full[RemW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_year_r  <= year_r;
      out_month_r <= month_r;
      out_day_r   <= day_r[DayW-1:0];
      out_bad_r   <= bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_day_r, out_month_r, out_year_r};
  assign out_tuser  = out_bad_r;

endmodule
`default_nettype wire

/* rtl/core/date_add_days.sv */
// Gregorian date advance: adds a count of days to a year, month and day.
//
// Input channel (in_*): one beat carries a starting date and a day count.
// Output channel (out_*): one beat per input beat carries the resulting date;
// out_tuser is high when the starting month was outside 1..12, and then the
// date is passed through unchanged.
//
// The day count is added to the day of month, and a sequencer then takes
// off one whole month per cycle until the day fits its month. The leap-year
// test uses the year split into a century count and a remainder, found by a
// reciprocal multiply after the beat is taken and kept current as years roll.
// Setup loads the beat, then finds the century count and then the remainder;
// the sequencer then steps the months, and the result is last loaded into
// the output register. A bad month goes from the century step to the output.
// One item is worked on at a time. in_tready rises again as soon as the
// result sits in the output register, so a new beat is taken while that
// result waits for the receiver. If the receiver stalls, the next result
// waits inside the block until the output register frees up.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid.
`default_nettype none
module date_add_days (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[38:23]
  input  wire logic [dad_pkg::InDataW-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // out_year[13:0], out_month[17:14], out_day[22:18]
  output logic [dad_pkg::OutDataW-1:0]      out_tdata,
  // bad_input[0]
  output logic                              out_tuser
);
  import dad_pkg::*;

  dad_cmd_t cmd;
  dad_sts_t sts;

  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dad_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* rtl/core/dad_checker.sv */
`default_nettype none
module dad_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [dad_pkg::OutDataW-1:0] out_tdata,
  input wire logic                         out_tuser
);
  import dad_pkg::*;

  // A reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Only one item is in work: no beat is taken right after another.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken on two consecutive cycles");

  // A stalled result keeps its beat unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output changed");

  a_bad_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((out_tdata[17:14] == 4'd0) || (out_tdata[17:14] > MonthDec)))
    else $error("bad flag with a legal month");

  a_good_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      ((out_tdata[17:14] != 4'd0) && (out_tdata[17:14] <= MonthDec)))
    else $error("result month out of range");

endmodule

bind date_add_days dad_checker u_dad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
